FILE: sv/hierarchical_sample_warping_top_assert.svh
// assertion macros for the sample warping block
`ifndef HIERARCHICAL_SAMPLE_WARPING_TOP_ASSERT_SVH
`define HIERARCHICAL_SAMPLE_WARPING_TOP_ASSERT_SVH

// condition holds whenever the trigger holds
`define HSW_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define HSW_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: sv/hsw_pkg.sv
`default_nettype none
package hsw_pkg;
  localparam int SAMPLE_W   = 16;
  localparam int NODE_W     = 22;
  localparam int SHARE_W    = 25;
  localparam int DIV_W      = 23;
  localparam int PROD_W     = NODE_W + SHARE_W;
  localparam int QUO_W      = 25;
  localparam int PC_W       = 16;
  localparam int INDEX_W    = 6;
  localparam int PTS_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NODE_AW_MAX = 7;
  localparam int LEAF_AW_MAX = 6;

  localparam logic [SHARE_W-1:0] SHARE_ONE = 25'h100_0000;
  localparam logic [PC_W-1:0] POINT_COUNT_RESET = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE   = 2'd1;

  typedef enum logic [4:0] {
    ST_LOAD, ST_B_RD0, ST_B_RD1, ST_B_WR, ST_ROOT, ST_LVL, ST_S_RD, ST_S_ACC,
    ST_P_RD0, ST_P_RD1, ST_P_RD2, ST_P_MUL0, ST_P_MUL1, ST_P_DIV, ST_P_WAIT,
    ST_P_WR0, ST_P_WR1, ST_O_RD, ST_O_CAP
  } state_t;

  typedef enum logic {NW_SAMPLE, NW_SUM} node_wsel_t;
  typedef enum logic [1:0] {SW_ROOT, SW_LEFT, SW_RIGHT} share_wsel_t;

  typedef struct packed {
    logic                   node_we;
    node_wsel_t             node_wsel;
    logic [NODE_AW_MAX-1:0] node_waddr;
    logic [NODE_AW_MAX-1:0] node_raddr;
    logic                   share_we;
    share_wsel_t            share_wsel;
    logic [LEAF_AW_MAX-1:0] share_waddr;
    logic [LEAF_AW_MAX-1:0] share_raddr;
    logic                   cap_a;
    logic                   cap_lp;
    logic                   cap_r;
    logic                   sum_clr;
    logic                   sum_acc;
    logic                   mul_l;
    logic                   mul_r;
    logic                   div_start;
    logic                   out_load;
    logic                   out_last;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_stall;
    logic norm_mode;
  } stat_t;
endpackage
`default_nettype wire

FILE: sv/hsw_sample_if.sv
`default_nettype none
interface hsw_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_value;
  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface
`default_nettype wire

FILE: sv/hsw_share_if.sv
`default_nettype none
interface hsw_share_if;
  logic        valid;
  logic        ready;
  logic [5:0]  leaf_index;
  logic [31:0] point_share;
  logic        zero_divisor;
  logic        last_share;
  modport source (output valid, output leaf_index, output point_share,
                  output zero_divisor, output last_share, input ready);
  modport sink (input valid, input leaf_index, input point_share,
                input zero_divisor, input last_share, output ready);
endinterface
`default_nettype wire

FILE: sv/hsw_divider.sv
`default_nettype none
module hsw_divider (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [hsw_pkg::PROD_W-1:0] dividend,
  input  wire logic [hsw_pkg::DIV_W-1:0]  divisor,
  output logic                           busy,
  output logic [hsw_pkg::QUO_W-1:0]      quotient
);
  import hsw_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic [DIV_W-1:0] rem;
  logic [QUO_W-1:0] low;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem, low[QUO_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QUO_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= DIV_W'(dividend[PROD_W-1:QUO_W]);
      low      <= dividend[QUO_W-1:0];
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      low      <= {low[QUO_W-2:0], 1'b0};
      quotient <= {quotient[QUO_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire

FILE: sv/hsw_ctrl.sv
`default_nettype none
module hsw_ctrl #(
  parameter int LEAVES = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  output logic                in_ready,
  input  wire hsw_pkg::stat_t stat,
  output hsw_pkg::cmd_t       cmd
);
  import hsw_pkg::*;

  localparam int LW  = $clog2(LEAVES);
  localparam int NA  = $clog2(2 * LEAVES - 1);
  localparam int LVW = $clog2(LW + 1);

  state_t         state, state_next;
  logic [LW-1:0]  idx, idx_next;
  logic [LVW-1:0] lv, lv_next;

  logic [LW:0]    wide_w;
  logic [LW:0]    wide_2w;
  logic [LW-1:0]  w_m1;
  logic [LW-1:0]  two_w_m1;
  logic [NA:0]    cb_wide;
  logic [NA-1:0]  cbase;
  logic [NA-1:0]  child0;
  logic [LW-1:0]  twice_idx;

  assign wide_w    = (LW + 1)'(1) << lv;
  assign wide_2w   = wide_w << 1;
  assign w_m1      = LW'(wide_w - 1'b1);
  assign two_w_m1  = LW'(wide_2w - 1'b1);
  assign cb_wide   = (NA + 1)'(2 * LEAVES) - ((NA + 1)'(wide_w) << 2);
  assign cbase     = cb_wide[NA-1:0];
  assign twice_idx = LW'({idx, 1'b0});
  assign child0    = cbase + NA'({idx, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      idx   <= '0;
      lv    <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      lv    <= lv_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    lv_next    = lv;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.node_we    = 1'b1;
          cmd.node_wsel  = NW_SAMPLE;
          cmd.node_waddr = NODE_AW_MAX'(idx);
          if (idx == LW'(LEAVES - 1)) begin
            idx_next   = '0;
            state_next = ST_B_RD0;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      ST_B_RD0: begin
        cmd.node_raddr = NODE_AW_MAX'({idx, 1'b0});
        state_next     = ST_B_RD1;
      end
      ST_B_RD1: begin
        cmd.node_raddr = NODE_AW_MAX'({idx, 1'b1});
        cmd.cap_a      = 1'b1;
        state_next     = ST_B_WR;
      end
      ST_B_WR: begin
        cmd.node_we    = 1'b1;
        cmd.node_wsel  = NW_SUM;
        cmd.node_waddr = NODE_AW_MAX'(NA'(LEAVES) + NA'(idx));
        if (idx == LW'(LEAVES - 2)) begin
          idx_next   = '0;
          lv_next    = '0;
          state_next = ST_ROOT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_B_RD0;
        end
      end
      ST_ROOT: begin
        cmd.share_we    = 1'b1;
        cmd.share_wsel  = SW_ROOT;
        cmd.share_waddr = '0;
        state_next      = ST_LVL;
      end
      ST_LVL: begin
        cmd.sum_clr = 1'b1;
        if (stat.norm_mode) begin
          idx_next   = '0;
          state_next = ST_S_RD;
        end else begin
          idx_next   = w_m1;
          state_next = ST_P_RD0;
        end
      end
      ST_S_RD: begin
        cmd.node_raddr = NODE_AW_MAX'(cbase + NA'(idx));
        state_next     = ST_S_ACC;
      end
      ST_S_ACC: begin
        cmd.sum_acc = 1'b1;
        if (idx == two_w_m1) begin
          idx_next   = w_m1;
          state_next = ST_P_RD0;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_S_RD;
        end
      end
      ST_P_RD0: begin
        cmd.node_raddr  = NODE_AW_MAX'(child0);
        cmd.share_raddr = LEAF_AW_MAX'(idx);
        state_next      = ST_P_RD1;
      end
      ST_P_RD1: begin
        cmd.node_raddr = NODE_AW_MAX'(child0 + 1'b1);
        cmd.cap_lp     = 1'b1;
        state_next     = ST_P_RD2;
      end
      ST_P_RD2: begin
        cmd.cap_r  = 1'b1;
        state_next = ST_P_MUL0;
      end
      ST_P_MUL0: begin
        cmd.mul_l  = 1'b1;
        state_next = ST_P_MUL1;
      end
      ST_P_MUL1: begin
        cmd.mul_r  = 1'b1;
        state_next = ST_P_DIV;
      end
      ST_P_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = ST_P_WAIT;
      end
      ST_P_WAIT: begin
        if (!stat.div_busy) begin
          state_next = ST_P_WR0;
        end
      end
      ST_P_WR0: begin
        cmd.share_we    = 1'b1;
        cmd.share_wsel  = SW_LEFT;
        cmd.share_waddr = LEAF_AW_MAX'(twice_idx);
        state_next      = ST_P_WR1;
      end
      ST_P_WR1: begin
        cmd.share_we    = 1'b1;
        cmd.share_wsel  = SW_RIGHT;
        cmd.share_waddr = LEAF_AW_MAX'(twice_idx + 1'b1);
        if (idx == '0) begin
          if (lv == LVW'(LW - 1)) begin
            idx_next   = '0;
            state_next = ST_O_RD;
          end else begin
            lv_next    = lv + 1'b1;
            state_next = ST_LVL;
          end
        end else begin
          idx_next   = idx - 1'b1;
          state_next = ST_P_RD0;
        end
      end
      ST_O_RD: begin
        cmd.share_raddr = LEAF_AW_MAX'(idx);
        state_next      = ST_O_CAP;
      end
      ST_O_CAP: begin
        cmd.share_raddr = LEAF_AW_MAX'(idx);
        cmd.out_last    = idx == LW'(LEAVES - 1);
        if (!stat.out_stall) begin
          cmd.out_load = 1'b1;
          if (idx == LW'(LEAVES - 1)) begin
            idx_next   = '0;
            state_next = ST_LOAD;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_O_RD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end
endmodule
`default_nettype wire

FILE: sv/hsw_datapath.sv
`default_nettype none
module hsw_datapath #(
  parameter int LEAVES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire hsw_pkg::cmd_t                 cmd,
  output hsw_pkg::stat_t                     stat,
  input  wire logic [hsw_pkg::SAMPLE_W-1:0]  sample_value,
  input  wire logic                          cfg_we,
  input  wire logic [hsw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hsw_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [hsw_pkg::INDEX_W-1:0]        leaf_index,
  output logic [hsw_pkg::PTS_W-1:0]          point_share,
  output logic                               zero_divisor,
  output logic                               last_share
);
  import hsw_pkg::*;

  localparam int LW    = $clog2(LEAVES);
  localparam int NA    = $clog2(2 * LEAVES - 1);
  localparam int ENT_W = SHARE_W + 1;
  localparam int OP_W  = SHARE_W + PC_W;

  logic [PC_W-1:0]   point_count;
  logic              norm_mode;

  logic [NODE_W-1:0] node_mem [2 * LEAVES - 1];
  logic [NODE_W-1:0] node_rd;
  logic [NODE_W-1:0] node_wdata;
  logic [ENT_W-1:0]  share_mem [LEAVES];
  logic [ENT_W-1:0]  share_rd;
  logic [ENT_W-1:0]  share_wdata;

  logic [NODE_W-1:0]  a_val;
  logic [NODE_W-1:0]  left;
  logic [NODE_W-1:0]  right;
  logic [SHARE_W-1:0] parent;
  logic               pflag;
  logic [DIV_W-1:0]   level_sum;
  logic [DIV_W-1:0]   divisor;
  logic [PROD_W-1:0]  prod_l;
  logic [PROD_W-1:0]  prod_r;
  logic [QUO_W-1:0]   quo_l;
  logic [QUO_W-1:0]   quo_r;
  logic               busy_l;
  logic               busy_r;
  logic               dz;
  logic [OP_W-1:0]    pts_full;
  logic [PTS_W:0]     pts;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RESET;
      norm_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POINT_COUNT: point_count <= cfg_data[PC_W-1:0];
        REG_NORM_MODE:   norm_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.node_wsel)
      NW_SAMPLE: node_wdata = NODE_W'(sample_value);
      default:   node_wdata = NODE_W'(a_val + node_rd);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.node_we) begin
      node_mem[cmd.node_waddr[NA-1:0]] <= node_wdata;
    end
    node_rd <= node_mem[cmd.node_raddr[NA-1:0]];
  end

  assign dz = divisor == '0;

  always_comb begin
    case (cmd.share_wsel)
      SW_ROOT:  share_wdata = {1'b0, SHARE_ONE};
      SW_LEFT:  share_wdata = dz ? {1'b1, {SHARE_W{1'b0}}} : {pflag, quo_l};
      default:  share_wdata = dz ? {1'b1, {SHARE_W{1'b0}}} : {pflag, quo_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.share_we) begin
      share_mem[cmd.share_waddr[LW-1:0]] <= share_wdata;
    end
    share_rd <= share_mem[cmd.share_raddr[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_val <= node_rd;
    end
    if (cmd.cap_lp) begin
      left   <= node_rd;
      parent <= share_rd[SHARE_W-1:0];
      pflag  <= share_rd[SHARE_W];
    end
    if (cmd.cap_r) begin
      right <= node_rd;
    end
    if (cmd.sum_clr) begin
      level_sum <= '0;
    end else if (cmd.sum_acc) begin
      level_sum <= level_sum + DIV_W'(node_rd);
    end
    if (cmd.mul_l) begin
      prod_l <= left * parent;
    end
    if (cmd.mul_r) begin
      prod_r  <= right * parent;
      divisor <= norm_mode ? level_sum : DIV_W'(left) + DIV_W'(right);
    end
  end

  hsw_divider u_div_l (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_l),
    .divisor  (divisor),
    .busy     (busy_l),
    .quotient (quo_l)
  );

  hsw_divider u_div_r (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (divisor),
    .busy     (busy_r),
    .quotient (quo_r)
  );

  assign pts_full = share_rd[SHARE_W-1:0] * point_count;
  assign pts      = pts_full[OP_W-1:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      leaf_index   <= INDEX_W'(cmd.share_raddr[LW-1:0]);
      point_share  <= pts[PTS_W] ? {PTS_W{1'b1}} : pts[PTS_W-1:0];
      zero_divisor <= share_rd[SHARE_W];
      last_share   <= cmd.out_last;
    end
  end

  assign stat.div_busy  = busy_l | busy_r;
  assign stat.out_stall = out_valid & ~out_ready;
  assign stat.norm_mode = norm_mode;
endmodule
`default_nettype wire

FILE: sv/hierarchical_sample_warping_top.sv
// hierarchical sample warping, one dimension
// sample_in takes LEAVES unsigned importance values, one per transfer, in
// leaf order; it is ready only while a run is loading.
// after the last sample the block sums the pyramid (two reads and a write per
// inner node), then walks it from the root: per inner node three reads, a
// multiply for each child and two 25-step restoring dividers running side by
// side, the divider iteration setting the pace.
// in mode 1 each level also reads every child node once for its sum.
// share_out then gives LEAVES results in leaf order, last_share marking the
// final leaf.
// a result waits in the output register while the receiver stalls; the walk
// holds until it is taken. the next run may load while the final result waits.
// cfg_we writes point_count (index 0) or norm_mode (index 1); other indexes
// are ignored. configure only while idle.
// rst is synchronous: the run restarts empty, point_count is 1000 and
// norm_mode is 0. the node and share memories are not cleared.
`default_nettype none
module hierarchical_sample_warping_top #(
  parameter int LEAVES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  hsw_sample_if.sink                           sample_in,
  hsw_share_if.source                          share_out,
  input  wire logic                            cfg_we,
  input  wire logic [hsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hsw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hsw_pkg::*;

  `include "hierarchical_sample_warping_top_assert.svh"

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  in_fire;

  assign in_fire         = sample_in.valid & in_ready;
  assign sample_in.ready = in_ready;

  hsw_ctrl #(.LEAVES(LEAVES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hsw_datapath #(.LEAVES(LEAVES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample_value (sample_in.sample_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (share_out.valid),
    .out_ready    (share_out.ready),
    .leaf_index   (share_out.leaf_index),
    .point_share  (share_out.point_share),
    .zero_divisor (share_out.zero_divisor),
    .last_share   (share_out.last_share)
  );

  // loading only resumes with at most the final result still pending
  `HSW_ASSERT_NOW(a_load_after_results, in_fire, !(share_out.valid && !share_out.last_share), "sample taken while results pending")
  // the final leaf carries the top index
  `HSW_ASSERT_NOW(a_last_index, share_out.valid && share_out.last_share, share_out.leaf_index == INDEX_W'(LEAVES - 1), "last flag on wrong leaf")
  // a result load never overwrites a stalled result
  `HSW_ASSERT_NEXT(a_no_overwrite, share_out.valid && !share_out.ready, $stable(share_out.point_share) && $stable(share_out.leaf_index), "stalled result changed")
endmodule
`default_nettype wire
